// ===== sv/ptb_pkg.sv =====
// ----------------------------------------------------------------------------
// ptb_pkg: shared types and constants of the periodic timer bank
// Op codes, command classes, queue entry, timer entry and back-end states.
// ----------------------------------------------------------------------------
package ptb_pkg;

    // default bank size and command queue depth
    localparam int TIMERS_DEF  = 8;
    localparam int QUEUE_DEPTH = 2;

    // op codes on the command port
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_STOP    = 3'd2;
    localparam logic [2:0] OP_TAKE    = 3'd3;
    localparam logic [2:0] OP_CHKSTOP = 3'd4;
    localparam logic [2:0] OP_CHKRUN  = 3'd5;

    // command class after decode
    typedef enum logic [2:0] {
        K_NOP,
        K_TICK,
        K_START,
        K_STOP,
        K_TAKE,
        K_CHKSTOP,
        K_CHKRUN
    } t_kind;

    // classified command as it travels through the queue
    typedef struct packed {
        t_kind       kind;
        logic        in_range;
        logic [7:0]  idx;
        logic [31:0] period;
        logic [15:0] amount;
    } t_cmd;

    // one timer as stored in the RAM
    typedef struct packed {
        logic        expired;
        logic [31:0] reload;
        logic [31:0] remaining;
    } t_entry;

    // back-end sequencer states
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SWEEP  = 4'b0010,
        S_READ   = 4'b0100,
        S_MODIFY = 4'b1000
    } t_state;

endpackage

// ===== sv/ptb_ram.sv =====
// ----------------------------------------------------------------------------
// ptb_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ptb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/ptb_front.sv =====
// ----------------------------------------------------------------------------
// ptb_front: command decode and range check
// Classifies the op, checks the timer index and raises the push into the queue.
// ----------------------------------------------------------------------------
module ptb_front
    import ptb_pkg::*;
#(
    parameter int TIMERS = TIMERS_DEF
) (
    input  logic        start,
    input  logic        i_full,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_timer_index,
    input  logic [31:0] i_period,
    input  logic [15:0] i_tick_amount,
    output logic        busy,
    output logic        o_push,
    output t_cmd        o_cmd
);

    // a start is taken whenever the queue has room
    assign busy   = i_full;
    assign o_push = start && !i_full;

    // op decode
    always_comb begin
        o_cmd.in_range = (9'(i_timer_index) < 9'(TIMERS));
        o_cmd.idx      = i_timer_index;
        o_cmd.period   = i_period;
        o_cmd.amount   = i_tick_amount;
        case (i_op)
            OP_TICK:    o_cmd.kind = K_TICK;
            OP_START:   o_cmd.kind = K_START;
            OP_STOP:    o_cmd.kind = K_STOP;
            OP_TAKE:    o_cmd.kind = K_TAKE;
            OP_CHKSTOP: o_cmd.kind = K_CHKSTOP;
            OP_CHKRUN:  o_cmd.kind = K_CHKRUN;
            default:    o_cmd.kind = K_NOP;
        endcase
    end

endmodule

// ===== sv/ptb_queue.sv =====
// ----------------------------------------------------------------------------
// ptb_queue: short command queue between decode and execution
// Register FIFO; lets the front take commands while the back is sweeping.
// ----------------------------------------------------------------------------
module ptb_queue
    import ptb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_valid,
    output logic o_full
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_cmd   = r_slot[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== sv/ptb_back.sv =====
// ----------------------------------------------------------------------------
// ptb_back: command execution
// Holds the pending time sum, sweeps it into every timer before a query and
// does the read-modify-write of the chosen timer in the timer RAM.
// ----------------------------------------------------------------------------
module ptb_back
    import ptb_pkg::*;
#(
    parameter int TIMERS = TIMERS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_valid,
    output logic o_pop,
    output logic o_strobe,
    output logic o_answer
);

    localparam int              AW   = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int              EW   = $bits(t_entry);
    localparam logic [AW-1:0]   LAST = AW'(TIMERS - 1);

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [31:0]        r_pend, n_pend;
    logic [AW-1:0]      r_cnt, n_cnt;
    logic               r_rd_done, n_rd_done;
    logic               r_dv, n_dv;
    logic [AW-1:0]      r_daddr, n_daddr;
    logic [TIMERS-1:0]  r_vld, n_vld;
    logic               r_rd_vld, n_rd_vld;
    logic               r_strobe, n_strobe;
    logic               r_answer, n_answer;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [EW-1:0]      rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    t_entry             wr_data;

    t_entry             ent;
    t_entry             swp;
    logic [32:0]        sum;

    // timer store: expired flag, interval and remaining time per timer
    ptb_ram #(
        .WIDTH (EW),
        .DEPTH (TIMERS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // never-written entries read as zero
    assign ent = r_rd_vld ? t_entry'(rd_data) : '0;

    // pending time applied to one timer: floor at zero, reload on expiry
    always_comb begin
        swp = ent;
        if (ent.remaining >= r_pend) begin
            swp.remaining = ent.remaining - r_pend;
        end else begin
            swp.remaining = '0;
        end
        if (swp.remaining == '0 && ent.reload != '0) begin
            swp.expired   = 1'b1;
            swp.remaining = ent.reload;
        end
    end

    // saturating tick sum
    assign sum = {1'b0, r_pend} + 33'(i_cmd.amount);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_pend    = r_pend;
        n_cnt     = r_cnt;
        n_rd_done = r_rd_done;
        n_dv      = 1'b0;
        n_daddr   = r_daddr;
        n_vld     = r_vld;
        n_strobe  = 1'b0;
        n_answer  = 1'b0;
        o_pop     = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = r_cnt;
        wr_en     = 1'b0;
        wr_addr   = r_daddr;
        wr_data   = ent;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    case (i_cmd.kind)
                        K_TICK: begin
                            n_pend   = sum[32] ? '1 : sum[31:0];
                            n_strobe = 1'b1;
                        end
                        K_START: begin
                            if (i_cmd.in_range) begin
                                wr_en             = 1'b1;
                                wr_addr           = i_cmd.idx[AW-1:0];
                                wr_data.expired   = 1'b0;
                                wr_data.reload    = i_cmd.period;
                                wr_data.remaining = i_cmd.period;
                            end
                            n_strobe = 1'b1;
                        end
                        K_STOP: begin
                            if (i_cmd.in_range) begin
                                n_state = S_READ;
                            end else begin
                                n_strobe = 1'b1;
                            end
                        end
                        K_TAKE, K_CHKSTOP, K_CHKRUN: begin
                            if (r_pend != '0) begin
                                n_state   = S_SWEEP;
                                n_cnt     = '0;
                                n_rd_done = 1'b0;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end

            // pipelined read, update, write back over all timers
            S_SWEEP: begin
                if (!r_rd_done) begin
                    rd_en   = 1'b1;
                    rd_addr = r_cnt;
                    n_dv    = 1'b1;
                    n_daddr = r_cnt;
                    if (r_cnt == LAST) begin
                        n_rd_done = 1'b1;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                if (r_dv) begin
                    wr_en   = 1'b1;
                    wr_addr = r_daddr;
                    wr_data = swp;
                    if (r_rd_done) begin
                        n_pend  = '0;
                        n_state = S_READ;
                    end
                end
            end

            S_READ: begin
                rd_en   = r_cmd.in_range;
                rd_addr = r_cmd.idx[AW-1:0];
                n_state = S_MODIFY;
            end

            // answer and write back of the chosen timer
            S_MODIFY: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
                wr_addr  = r_cmd.idx[AW-1:0];
                case (r_cmd.kind)
                    K_STOP: begin
                        wr_en          = r_cmd.in_range;
                        wr_data.reload = '0;
                    end
                    K_TAKE: begin
                        n_answer        = r_cmd.in_range && ent.expired;
                        wr_en           = r_cmd.in_range && ent.expired;
                        wr_data.expired = 1'b0;
                    end
                    K_CHKSTOP: begin
                        n_answer = r_cmd.in_range && (ent.reload == '0);
                    end
                    K_CHKRUN: begin
                        n_answer = r_cmd.in_range && ((ent.reload != '0) || ent.expired);
                    end
                    default: begin
                        n_answer = 1'b0;
                    end
                endcase
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // entry valid bits track the read and every write
        n_rd_vld = rd_en ? r_vld[rd_addr] : 1'b0;
        if (wr_en) begin
            n_vld[wr_addr] = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend    <= '0;
            r_cnt     <= '0;
            r_rd_done <= 1'b0;
            r_dv      <= 1'b0;
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_strobe  <= 1'b0;
            r_answer  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_cnt     <= n_cnt;
            r_rd_done <= n_rd_done;
            r_dv      <= n_dv;
            r_vld     <= n_vld;
            r_rd_vld  <= n_rd_vld;
            r_strobe  <= n_strobe;
            r_answer  <= n_answer;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_daddr <= n_daddr;
    end

    assign o_strobe = r_strobe;
    assign o_answer = r_answer;

endmodule

// ===== sv/periodic_timer_bank.sv =====
// Sequence: tick, start and commands with no effect are answered from S_IDLE;
//   an in-range stop and a query with no pending time pass through S_READ and
//   S_MODIFY; a query with pending time first runs the one-timer-per-cycle RAM sweep.
// Execution: one command per back-end pass; a
//   2-entry queue absorbs new commands meanwhile. The receiver cannot stall.
// Reset: synchronous, active low; all timers read as zero at once, no clearing pass.
// ----------------------------------------------------------------------------
// periodic_timer_bank: bank of periodic interval timers
// Front decodes commands into a short queue; back applies elapsed time and
// executes timer control and queries against a timer RAM.
// ----------------------------------------------------------------------------
module periodic_timer_bank
    import ptb_pkg::*;
#(
    parameter int TIMERS = TIMERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_timer_index,
    input  logic [31:0] i_period,
    input  logic [15:0] i_tick_amount,
    output logic        busy,
    output logic        o_strobe,
    output logic        o_answer
);

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic push;
    logic pop;
    logic q_valid;
    logic q_full;

    // decode
    ptb_front #(
        .TIMERS (TIMERS)
    ) u_front (
        .start         (start),
        .i_full        (q_full),
        .i_op          (i_op),
        .i_timer_index (i_timer_index),
        .i_period      (i_period),
        .i_tick_amount (i_tick_amount),
        .busy          (busy),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    // command queue
    ptb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    // execution
    ptb_back #(
        .TIMERS (TIMERS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (queue_cmd),
        .i_valid  (q_valid),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_answer (o_answer)
    );

endmodule

// ===== sv/ptb_checker.sv =====
// ----------------------------------------------------------------------------
// ptb_checker: port-level checks for the periodic timer bank
// Tracks commands in flight and checks results against them.
// ----------------------------------------------------------------------------
module ptb_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic busy,
    input  logic o_strobe,
    input  logic o_answer
);

    logic [2:0] r_out;
    logic       xfer;

    assign xfer = start && !busy;

    // commands transferred but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (xfer && !o_strobe) begin
            r_out <= r_out + 1'b1;
        end else if (!xfer && o_strobe) begin
            r_out <= r_out - 1'b1;
        end
    end

    // reset leaves no result pending and the port open
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !busy)
        else $error("result or busy right after reset");

    // no result without an earlier command
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> r_out != 3'd0)
        else $error("result without outstanding command");

    // at most queue plus one command in execution outstanding
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out <= 3'd3)
        else $error("too many commands outstanding");

    // full pipeline must push back
    a_full_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out == 3'd3 |-> busy)
        else $error("command taken with queue full");

    // answer is only shown with its strobe
    a_answer_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_strobe |-> !o_answer)
        else $error("answer high without strobe");

endmodule

bind periodic_timer_bank ptb_checker u_ptb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_answer (o_answer)
);
